[sv/lksm_pkg.sv]
// Shared constants, sequence table, types and helpers for the leader-key sequence matcher.
package lksm_pkg;

  localparam int MaxSeqLen = 6;
  localparam int NumSeq    = 29;
  localparam int HoldSlots = 6;
  localparam int NumGreek  = 24;
  localparam int LenW      = $clog2(MaxSeqLen + 1);
  localparam int AtW       = $clog2(MaxSeqLen);
  localparam int ActW      = 5;
  localparam int KeyW      = 8;
  localparam int RowW      = 4;
  localparam int ColW      = 5;
  localparam int PosW      = RowW + ColW;
  localparam int CpW       = 16;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 32;

  localparam logic [KeyW-1:0] KeyNone  = 8'd0;
  localparam logic [KeyW-1:0] KeyFirst = 8'd4;
  localparam logic [KeyW-1:0] KeyLast  = 8'd29;

  localparam logic [CpW-1:0] CpPhiSym   = 16'h03D5;
  localparam logic [CpW-1:0] CpPhiUpper = 16'h03A6;
  localparam logic [CpW-1:0] CpCaseStep = 16'h0020;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [NumSeq-1:0] next_mask;
    logic              done;
    logic [ActW-1:0]   act;
  } match_t;

  function automatic logic [KeyW-1:0] lk(input logic [7:0] c);
    return c - 8'd61;
  endfunction

  localparam logic [KeyW-1:0] SEQ_KEYS [NumSeq][MaxSeqLen] = '{
    '{lk("E"), lk("A"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("B"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("G"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("D"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("E"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("Z"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("H"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("V"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("I"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("K"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("L"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("M"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("N"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("X"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("O"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("P"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("R"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("S"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("T"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("U"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("F"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("C"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("Y"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("E"), lk("W"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("L"), lk("F"), KeyNone, KeyNone, KeyNone, KeyNone},
    '{lk("D"), lk("S"), lk("E"), lk("N"), lk("D"), KeyNone},
    '{lk("Q"), lk("W"), lk("E"), lk("R"), lk("T"), lk("Y")},
    '{lk("R"), lk("E"), lk("S"), lk("E"), lk("T"), KeyNone},
    '{lk("B"), lk("O"), lk("O"), lk("T"), KeyNone, KeyNone}
  };

  localparam logic [LenW-1:0] SEQ_LEN [NumSeq] = '{
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd5, 3'd6, 3'd5, 3'd4
  };

  localparam logic [CpW-1:0] GREEK_LOWER [NumGreek] = '{
    16'h03B1, 16'h03B2, 16'h03B3, 16'h03B4, 16'h03B5, 16'h03B6, 16'h03B7, 16'h03B8,
    16'h03B9, 16'h03BA, 16'h03BB, 16'h03BC, 16'h03BD, 16'h03BE, 16'h03BF, 16'h03C0,
    16'h03C1, 16'h03C3, 16'h03C4, 16'h03C5, 16'h03D5, 16'h03C7, 16'h03C8, 16'h03C9
  };

  function automatic logic [CpW-1:0] greek_cp(input logic [ActW-1:0] act,
                                              input logic upper);
    logic [CpW-1:0] cp;
    cp = '0;
    if (act < ActW'(NumGreek)) begin
      cp = GREEK_LOWER[act];
      if (upper) begin
        cp = (cp == CpPhiSym) ? CpPhiUpper : cp - CpCaseStep;
      end
    end
    return cp;
  endfunction

endpackage

[sv/lksm_match.sv]
// Parallel compare of one key against every candidate sequence of the table.
module lksm_match (
  input  logic [lksm_pkg::KeyW-1:0]   key_code_i,
  input  logic [lksm_pkg::AtW-1:0]    at_i,
  input  logic [lksm_pkg::LenW-1:0]   next_len_i,
  input  logic [lksm_pkg::NumSeq-1:0] cand_i,
  output lksm_pkg::match_t            match_o
);
  import lksm_pkg::*;

  logic [NumSeq-1:0] hit;

  always_comb begin
    for (int i = 0; i < NumSeq; i++) begin
      hit[i] = cand_i[i] && (SEQ_KEYS[i][at_i] == key_code_i);
    end
  end

  // The lowest completing entry wins, so scan from the top down.
  always_comb begin
    match_o.next_mask = hit;
    match_o.done      = 1'b0;
    match_o.act       = '0;
    for (int i = NumSeq - 1; i >= 0; i--) begin
      if (hit[i] && (SEQ_LEN[i] == next_len_i)) begin
        match_o.done = 1'b1;
        match_o.act  = ActW'(i);
      end
    end
  end

endmodule

[sv/leader_key_sequence_matcher_unit.sv]
// Top level of the leader-key sequence matcher with stream input and output.
// The unit takes one beat per clock cycle unless held by a stalled result, and returns exactly
// one result beat for each input beat: a beat is captured in an input register, the table
// compare and state update run once the output register is free or being drained, and the
// result sits in an output register until it is taken. The input side keeps accepting while
// a result waits, as long as the input register is empty or the result is drained in that cycle.
module leader_key_sequence_matcher_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: shift_flag, shift_passthrough, key_code[7:0], key_row[3:0], key_col[4:0]
  input  logic [lksm_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: opcode[1:0]
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: consumed, action_fired, action[4:0], uppercase, greek_char[15:0], leader_armed
  output logic [lksm_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import lksm_pkg::*;

  logic              in_vld_q;
  logic [1:0]        in_op_q;
  logic              in_sflag_q, in_spass_q;
  logic [KeyW-1:0]   in_key_q;
  logic [PosW-1:0]   in_pos_q;

  logic              out_vld_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic              armed_q, armed_d;
  logic              shifted_q, shifted_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [NumSeq-1:0] cand_q, cand_d;
  logic [PosW-1:0]   held_pos_q [HoldSlots];
  logic [HoldSlots-1:0] held_vld_q, held_vld_d;

  logic              step;
  logic              take_en;
  logic [$clog2(HoldSlots)-1:0] take_slot;
  logic              free_found;
  logic              rel_found;
  logic [$clog2(HoldSlots)-1:0] rel_slot;
  logic              consumed, fired, upper;
  logic [ActW-1:0]   act;
  logic [CpW-1:0]    cp;
  match_t            match;

  assign step            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || step;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  lksm_match u_match (
    .key_code_i (in_key_q),
    .at_i       (len_q[AtW-1:0]),
    .next_len_i (len_q + LenW'(1)),
    .cand_i     (cand_q),
    .match_o    (match)
  );

  always_comb begin
    free_found = 1'b0;
    take_slot  = '0;
    rel_found  = 1'b0;
    rel_slot   = '0;
    for (int s = HoldSlots - 1; s >= 0; s--) begin
      if (!held_vld_q[s]) begin
        free_found = 1'b1;
        take_slot  = ($clog2(HoldSlots))'(s);
      end
      if (held_vld_q[s] && (held_pos_q[s] == in_pos_q)) begin
        rel_found = 1'b1;
        rel_slot  = ($clog2(HoldSlots))'(s);
      end
    end
  end

  always_comb begin
    armed_d    = armed_q;
    shifted_d  = shifted_q;
    len_d      = len_q;
    cand_d     = cand_q;
    held_vld_d = held_vld_q;
    take_en    = 1'b0;
    consumed   = 1'b0;
    fired      = 1'b0;
    upper      = 1'b0;
    act        = '0;
    cp         = '0;
    unique case (in_op_q)
      OP_START: begin
        if (held_vld_q == '0) begin
          armed_d   = 1'b1;
          shifted_d = in_sflag_q;
          len_d     = '0;
          cand_d    = '1;
        end
      end
      OP_RELEASE: begin
        if (rel_found) begin
          consumed             = 1'b1;
          held_vld_d[rel_slot] = 1'b0;
        end
      end
      OP_PRESS: begin
        if (armed_q && !in_spass_q) begin
          if ((in_key_q < KeyFirst) || (in_key_q > KeyLast) ||
              (len_q >= LenW'(MaxSeqLen)) || (match.next_mask == '0)) begin
            armed_d   = 1'b0;
            shifted_d = 1'b0;
            len_d     = '0;
            cand_d    = '0;
          end else begin
            consumed = 1'b1;
            take_en  = free_found;
            if (free_found) begin
              held_vld_d[take_slot] = 1'b1;
            end
            len_d  = len_q + LenW'(1);
            cand_d = match.next_mask;
            if (match.done) begin
              fired     = 1'b1;
              upper     = shifted_q || in_sflag_q;
              act       = match.act;
              cp        = greek_cp(match.act, shifted_q || in_sflag_q);
              armed_d   = 1'b0;
              shifted_d = 1'b0;
              len_d     = '0;
              cand_d    = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    out_data_d = {7'b0, armed_d, cp, upper, act, fired, consumed};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      armed_q    <= 1'b0;
      shifted_q  <= 1'b0;
      len_q      <= '0;
      cand_q     <= '0;
      held_vld_q <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q  <= 1'b1;
        armed_q    <= armed_d;
        shifted_q  <= shifted_d;
        len_q      <= len_d;
        cand_q     <= cand_d;
        held_vld_q <= held_vld_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_op_q    <= s_axis_tuser_i;
      in_sflag_q <= s_axis_tdata_i[0];
      in_spass_q <= s_axis_tdata_i[1];
      in_key_q   <= s_axis_tdata_i[9:2];
      in_pos_q   <= {s_axis_tdata_i[13:10], s_axis_tdata_i[18:14]};
    end
    if (step) begin
      out_data_q <= out_data_d;
      if (take_en) begin
        held_pos_q[take_slot] <= in_pos_q;
      end
    end
  end

endmodule

[sv/lksm_checker.sv]
// Port-level checker for the leader-key sequence matcher and its bind statement.
module lksm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [lksm_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import lksm_pkg::*;

  // A result beat that is not taken stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result beat changed");

  // The input side only holds back while a result beat is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input beat refused without a stalled result");

  // A fired action always swallows the key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |-> m_axis_tdata_o[0])
    else $error("action fired on a key that was passed on");

  // Completing a sequence leaves the matcher disarmed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |-> !m_axis_tdata_o[24])
    else $error("matcher still armed after an action fired");

  // Without a fired action the action fields read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[1] |-> m_axis_tdata_o[23:2] == '0)
    else $error("action fields set without a fired action");

endmodule

bind leader_key_sequence_matcher_unit lksm_checker u_lksm_checker (.*);
